>>> rtl/core/sha1md_pkg.sv
package sha1md_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        REQ_BYTE     = 2'd0,
        REQ_BYTE_FIN = 2'd1,
        REQ_FIN      = 2'd2,
        REQ_NONE     = 2'd3
    } t_req;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned ROUNDS       = 80;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

>>> rtl/core/sha1_message_digest.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------
// input    | i_valid / o_ready  | i_req_type, i_msg_byte
// output   | o_valid / i_ready  | o_digest_word, o_word_index, o_digest_last
//
// Each full 64-byte block runs 80 rounds through one round adder, then folds the
// working words into the chaining state one word at a time through one 32-bit
// adder. A finish inserts one padding or length byte per cycle, compresses once
// or twice, then presents the five words one per accepted cycle. o_ready is low
// from the finish until the last word is taken. Reset (i_rst_n, synchronous)
// loads the initial hash values and clears the fill count and length.
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_msg_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);

    sha1md_pkg::t_state r_state, n_state;

    logic [31:0]  r_h [sha1md_pkg::DIGEST_WORDS];
    logic [31:0]  n_h [sha1md_pkg::DIGEST_WORDS];
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_len, n_len;
    logic         r_fin, n_fin;
    logic         r_mark, n_mark;
    logic         r_len_done, n_len_done;
    logic [2:0]   r_lcnt, n_lcnt;
    logic [6:0]   r_rnd, n_rnd;
    logic [2:0]   r_fcnt, n_fcnt;
    logic [2:0]   r_oidx, n_oidx;

    // block window and working words
    logic [511:0] r_blk, n_blk;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  n_a, n_b, n_c, n_d, n_e;

    logic [31:0]  wt, f, k, tmp;
    logic [7:0]   pad_byte;
    logic         in_acc;

    assign o_ready       = (r_state == sha1md_pkg::ST_IDLE);
    assign o_valid       = (r_state == sha1md_pkg::ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_digest_last = (r_oidx == 3'(sha1md_pkg::DIGEST_WORDS - 1));
    assign in_acc        = i_valid && o_ready;

    // shared round unit
    always_comb begin
        if (r_rnd < 7'd16) begin
            wt = r_blk[511:480];
        end else begin
            wt = sha1md_pkg::rotl1(r_blk[95:64] ^ r_blk[255:224] ^
                                   r_blk[447:416] ^ r_blk[511:480]);
        end
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = sha1md_pkg::K_R0;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = sha1md_pkg::K_R1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = sha1md_pkg::K_R2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = sha1md_pkg::K_R3;
        end
        tmp = sha1md_pkg::rotl5(r_a) + f + r_e + k + wt;
    end

    // padding byte source: marker, zeros up to the length slot, then length
    always_comb begin
        if (!r_mark) begin
            pad_byte = sha1md_pkg::PAD_MARK;
        end else if (r_lcnt == 3'd0 && r_fill != sha1md_pkg::LEN_POS) begin
            pad_byte = 8'h00;
        end else begin
            pad_byte = r_len[63:56];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_h        = r_h;
        n_fill     = r_fill;
        n_len      = r_len;
        n_fin      = r_fin;
        n_mark     = r_mark;
        n_len_done = r_len_done;
        n_lcnt     = r_lcnt;
        n_rnd      = r_rnd;
        n_fcnt     = r_fcnt;
        n_oidx     = r_oidx;
        n_blk      = r_blk;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_d        = r_d;
        n_e        = r_e;

        unique case (r_state)
            sha1md_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (sha1md_pkg::t_req'(i_req_type)) inside
                        sha1md_pkg::REQ_BYTE, sha1md_pkg::REQ_BYTE_FIN: begin
                            n_blk  = {r_blk[503:0], i_msg_byte};
                            n_fill = r_fill + 6'd1;
                            n_len  = r_len + 64'd8;
                            n_fin  = (i_req_type == sha1md_pkg::REQ_BYTE_FIN);
                            if (r_fill == 6'd63) begin
                                n_state = sha1md_pkg::ST_COMP;
                            end else if (i_req_type == sha1md_pkg::REQ_BYTE_FIN) begin
                                n_state = sha1md_pkg::ST_PAD;
                            end
                        end
                        sha1md_pkg::REQ_FIN: begin
                            n_fin   = 1'b1;
                            n_state = sha1md_pkg::ST_PAD;
                        end
                        default: begin
                            // unused code: drop the item
                        end
                    endcase
                end
            end
            sha1md_pkg::ST_PAD: begin
                n_blk  = {r_blk[503:0], pad_byte};
                n_fill = r_fill + 6'd1;
                n_mark = 1'b1;
                if (r_mark && (r_lcnt != 3'd0 || r_fill == sha1md_pkg::LEN_POS)) begin
                    n_len  = {r_len[55:0], 8'h00};
                    n_lcnt = r_lcnt + 3'd1;
                    if (r_lcnt == 3'd7) begin
                        n_len_done = 1'b1;
                    end
                end
                if (r_fill == 6'd63) begin
                    n_state = sha1md_pkg::ST_COMP;
                end
            end
            sha1md_pkg::ST_COMP: begin
                n_blk = {r_blk[479:0], wt};
                n_e   = r_d;
                n_d   = r_c;
                n_c   = sha1md_pkg::rotl30(r_b);
                n_b   = r_a;
                n_a   = tmp;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'(sha1md_pkg::ROUNDS - 1)) begin
                    n_rnd   = 7'd0;
                    n_fcnt  = 3'd0;
                    n_state = sha1md_pkg::ST_FOLD;
                end
            end
            sha1md_pkg::ST_FOLD: begin
                // rotate both word sets so one adder folds each pair in turn
                for (int i = 0; i < sha1md_pkg::DIGEST_WORDS - 1; i++) begin
                    n_h[i] = r_h[i + 1];
                end
                n_h[sha1md_pkg::DIGEST_WORDS - 1] = r_h[0] + r_a;
                n_a    = r_b;
                n_b    = r_c;
                n_c    = r_d;
                n_d    = r_e;
                n_e    = r_a;
                n_fcnt = r_fcnt + 3'd1;
                if (r_fcnt == 3'(sha1md_pkg::DIGEST_WORDS - 1)) begin
                    if (!r_fin) begin
                        n_state = sha1md_pkg::ST_IDLE;
                    end else if (r_len_done) begin
                        n_oidx  = 3'd0;
                        n_state = sha1md_pkg::ST_OUT;
                    end else begin
                        n_state = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'(sha1md_pkg::DIGEST_WORDS - 1)) begin
                        // reseed; length already shifted out to zero
                        n_h        = sha1md_pkg::H_INIT;
                        n_fill     = 6'd0;
                        n_len      = 64'd0;
                        n_fin      = 1'b0;
                        n_mark     = 1'b0;
                        n_len_done = 1'b0;
                        n_lcnt     = 3'd0;
                        n_oidx     = 3'd0;
                        n_state    = sha1md_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha1md_pkg::ST_IDLE;
            end
        endcase

        // load the working words on entry to the rounds
        if (n_state == sha1md_pkg::ST_COMP && r_state != sha1md_pkg::ST_COMP) begin
            n_a   = r_h[0];
            n_b   = r_h[1];
            n_c   = r_h[2];
            n_d   = r_h[3];
            n_e   = r_h[4];
            n_rnd = 7'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1md_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h        <= sha1md_pkg::H_INIT;
            r_fill     <= 6'd0;
            r_len      <= 64'd0;
            r_fin      <= 1'b0;
            r_mark     <= 1'b0;
            r_len_done <= 1'b0;
            r_lcnt     <= 3'd0;
            r_rnd      <= 7'd0;
            r_fcnt     <= 3'd0;
            r_oidx     <= 3'd0;
        end else begin
            r_h        <= n_h;
            r_fill     <= n_fill;
            r_len      <= n_len;
            r_fin      <= n_fin;
            r_mark     <= n_mark;
            r_len_done <= n_len_done;
            r_lcnt     <= n_lcnt;
            r_rnd      <= n_rnd;
            r_fcnt     <= n_fcnt;
            r_oidx     <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
    end

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 470;
    localparam int unsigned TAIL_CYCLES  = 400;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned REPORT_MAX   = 10;

    localparam logic [31:0] SHA1_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  pos;
        logic        last;
    } t_digest_word;

    class sha1_scoreboard;
        logic [31:0]  chain [5];
        logic [7:0]   block_buf [64];
        int unsigned  fill;
        logic [63:0]  msg_bits;
        t_digest_word digest_q [$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
            foreach (block_buf[i]) block_buf[i] = 8'h00;
            reseed();
        endfunction

        function void reseed();
            foreach (chain[i]) chain[i] = SHA1_IV[i];
            fill     = 0;
            msg_bits = 64'd0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int unsigned n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t_next;
            for (int t = 0; t < 16; t++)
                w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
            for (int t = 16; t < 80; t++)
                w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t_next = rol(a, 5) + f + e + k + w[t];
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = t_next;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void absorb(logic [7:0] data);
            block_buf[fill] = data;
            fill++;
            if (fill == 64) begin
                fill = 0;
                compress();
            end
        endfunction

        function void note_input(sha1md_pkg::t_req req, logic [7:0] data);
            logic [63:0]  len;
            t_digest_word dw;
            if (req == sha1md_pkg::REQ_BYTE || req == sha1md_pkg::REQ_BYTE_FIN) begin
                absorb(data);
                msg_bits += 64'd8;
            end
            if (req == sha1md_pkg::REQ_BYTE_FIN || req == sha1md_pkg::REQ_FIN) begin
                len = msg_bits;
                absorb(8'h80);
                while (fill != 56)
                    absorb(8'h00);
                for (int i = 0; i < 8; i++)
                    absorb(len[63-8*i -: 8]);
                for (int i = 0; i < 5; i++) begin
                    dw.value = chain[i];
                    dw.pos   = 3'(i);
                    dw.last  = (i == 4);
                    digest_q.push_back(dw);
                end
                reseed();
            end
        endfunction

        function void check_result(logic [31:0] value, logic [2:0] pos, logic last);
            t_digest_word want;
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected digest word %08h index %0d last %0b",
                             value, pos, last);
            end else begin
                want = digest_q.pop_front();
                if (want.value !== value || want.pos !== pos || want.last !== last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("digest mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                                 want.value, want.pos, want.last, value, pos, last);
                end
            end
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [7:0]  i_msg_byte;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_digest_last;

    sha1_scoreboard sb;
    bit             tx_burst = 1'b0;
    int unsigned    items_sent = 0;
    int unsigned    quiet_cycles = 0;

    sha1_message_digest dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_msg_byte    (i_msg_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_digest_last (o_digest_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_item(input sha1md_pkg::t_req req, input logic [7:0] data);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_valid    <= 1'b0;
            i_req_type <= 2'($urandom);
            i_msg_byte <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_msg_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(req, data);
        if (req != sha1md_pkg::REQ_NONE)
            items_sent++;
    endtask

    // hold off the sender until every digest word has come back
    task automatic wait_for_digests();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_message(input int unsigned len, input bit fin_on_byte);
        int unsigned body;
        body     = (fin_on_byte && len != 0) ? len - 1 : len;
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < body; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(sha1md_pkg::REQ_NONE, 8'($urandom));
            send_item(sha1md_pkg::REQ_BYTE, 8'($urandom));
        end
        if (fin_on_byte && len != 0)
            send_item(sha1md_pkg::REQ_BYTE_FIN, 8'($urandom));
        else
            send_item(sha1md_pkg::REQ_FIN, 8'($urandom));
    endtask

    initial begin
        int unsigned pick;
        int unsigned len;
        sb = new();
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_req_type <= sha1md_pkg::REQ_NONE;
        i_msg_byte <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(sha1md_pkg::REQ_FIN, 8'h00);        // empty message
        send_item(sha1md_pkg::REQ_NONE, 8'hFF);       // unused code, must be dropped
        send_item(sha1md_pkg::REQ_FIN, 8'hFF);        // empty again after reseed
        send_item(sha1md_pkg::REQ_BYTE, 8'h61);
        send_item(sha1md_pkg::REQ_NONE, 8'h00);
        send_item(sha1md_pkg::REQ_BYTE, 8'h62);
        send_item(sha1md_pkg::REQ_BYTE_FIN, 8'h63);
        send_item(sha1md_pkg::REQ_BYTE, 8'h00);
        send_item(sha1md_pkg::REQ_BYTE, 8'hFF);
        send_item(sha1md_pkg::REQ_BYTE_FIN, 8'h80);
        send_item(sha1md_pkg::REQ_BYTE_FIN, 8'hFF);
        wait_for_digests();

        // lengths favour short messages and cluster near block padding boundaries
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                len = $urandom_range(0, 15);
            else if (pick < 70)
                len = $urandom_range(16, 51);
            else if (pick < 88)
                len = $urandom_range(52, 66);
            else if (pick < 96)
                len = $urandom_range(116, 130);
            else
                len = $urandom_range(180, 200);
            // trim the last message to the remaining item budget
            if (len > RANDOM_ITEMS - items_sent)
                len = RANDOM_ITEMS - items_sent;
            send_message(len, 1'($urandom));
            if ($urandom_range(0, 4) == 0)
                wait_for_digests();
        end

        wait_for_digests();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned stall;
        int unsigned calm_left;
        calm_left = 0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (calm_left != 0) begin
                stall = 0;
                calm_left--;
            end else begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 9) == 0)
                    calm_left = $urandom_range(5, 20);
            end
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_digest_word, o_word_index, o_digest_last);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> filelist.f
rtl/core/sha1md_pkg.sv
rtl/core/sha1_message_digest.sv
test/tb.sv
